>>> hw/rtl/rctm_pkg.sv
// Shared types and constants for the RC charge-time to millivolts converter.
package rctm_pkg;

    // Configuration register indexes
    localparam logic CFG_EXP_GAIN   = 1'b0;
    localparam logic CFG_FULL_SCALE = 1'b1;

    // Register reset values
    localparam logic [15:0] GAIN_RESET = 16'd4034;
    localparam logic [15:0] FULL_RESET = 16'd6600;

    // Above this exponent product exp2 is taken as zero
    localparam logic [46:0] UNDERFLOW_LIM = 47'h0000_6a00_0000;

    // Rounding bias for the integer part: k = ceil((p - 0.5) / 1.0) in s5.26
    localparam logic [31:0] K_ROUND = 32'h01ff_ffff;

    // 1.0 in s5.26
    localparam logic [26:0] ONE_S26 = 27'h400_0000;

    // Horner steps: leading coefficient, then the value added after each multiply
    localparam int HORNER_STEPS = 6;
    localparam logic signed [31:0] HORNER_C6 = 32'sd10535907;
    localparam logic signed [31:0] HORNER_ADD [HORNER_STEPS] = '{
        32'sd46003595,
        32'sd165241817,
        32'sd476772627,
        32'sd1031764999,
        32'sd1488522244,
        32'sd0
    };

    // Side data that travels with each beat through the polynomial
    typedef struct packed {
        logic       uf;   // exponent underflow, result saturates
        logic [4:0] k;    // integer part of the exponent
    } t_side;

endpackage

>>> hw/rtl/rctm_horner.sv
// Six-stage Horner pipeline for exp2 of the fraction, one multiply per stage.
module rctm_horner import rctm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_f,
    input  t_side              i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_r,
    output t_side              o_side
);

    logic [HORNER_STEPS-1:0] r_v;
    logic signed [31:0]      r_r    [HORNER_STEPS];
    logic signed [31:0]      r_f    [HORNER_STEPS-1];
    t_side                   r_side [HORNER_STEPS];
    logic [HORNER_STEPS:0]   w_rdy;

    assign w_rdy[HORNER_STEPS] = i_ready;
    assign o_ready             = w_rdy[0];

    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
        logic               w_v_in;
        logic signed [31:0] w_r_in;
        logic signed [31:0] w_f_in;
        t_side              w_side_in;
        logic signed [63:0] w_prod;

        // Stage inputs: module port for the first step, previous step otherwise
        if (j == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_r_in    = HORNER_C6;
            assign w_f_in    = i_f;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[j-1];
            assign w_r_in    = r_r[j-1];
            assign w_f_in    = r_f[j-1];
            assign w_side_in = r_side[j-1];
        end

        // Stage advances when empty or when downstream takes its beat
        assign w_rdy[j] = !r_v[j] || w_rdy[j+1];

        // High half of the signed product is a floor shift by 32
        assign w_prod = w_r_in * w_f_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_v[j] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j] && w_v_in) begin
                r_r[j]    <= w_prod[63:32] + HORNER_ADD[j];
                r_side[j] <= w_side_in;
            end
        end

        // Fraction is only needed by the steps that follow
        if (j < HORNER_STEPS - 1) begin : g_keep_f
            always_ff @(posedge i_clk) begin
                if (w_rdy[j] && w_v_in) begin
                    r_f[j] <= w_f_in;
                end
            end
        end
    end

    assign o_valid = r_v[HORNER_STEPS-1];
    assign o_r     = r_r[HORNER_STEPS-1];
    assign o_side  = r_side[HORNER_STEPS-1];

endmodule

>>> hw/rtl/rc_charge_time_to_millivolts_unit.sv
// Top level of the RC charge-time to millivolts converter.
//
// Converts a 31-bit charge-time count into millivolts as
// full_scale * (1 - exp2(-count * exponent_gain / 2^26)). The pipeline is ten
// register stages deep: gain multiply, exponent split, six polynomial
// multiply stages, exp2 rounding/shift, and the full-scale multiply into the
// output register. One beat enters per clock while the input is not held off
// by a stall. Each stage holds its beat only while the next is full, so a
// stalled output does not block input until the whole pipe is occupied.
// Configuration writes are taken in every cycle and must only happen while
// the pipe is empty.
module rc_charge_time_to_millivolts_unit import rctm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [30:0] i_charge_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_millivolts,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_gain;
    logic [15:0] r_full_scale;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= GAIN_RESET;
            r_full_scale <= FULL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXP_GAIN:   r_gain       <= i_cfg_data;
                CFG_FULL_SCALE: r_full_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: exponent product count * gain
    logic        r_s1_v;
    logic [46:0] r_s1_p;
    logic [46:0] n_s1_p;
    logic        w_s1_rdy;
    logic        w_s2_rdy;

    assign w_s1_rdy   = !r_s1_v || w_s2_rdy;
    assign o_in_ready = w_s1_rdy;
    assign n_s1_p     = {16'd0, i_charge_count} * {31'd0, r_gain};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_s1_rdy) begin
            r_s1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_rdy && i_in_valid) begin
            r_s1_p <= n_s1_p;
        end
    end

    // Stage 2: split into integer part and fraction in [-0.5, 0.5), scaled by 32
    logic               r_s2_v;
    logic signed [31:0] r_s2_f;
    t_side              r_s2_side;
    logic [31:0]        w_ksum;
    logic [4:0]         w_k;
    logic [30:0]        w_d;
    logic signed [31:0] n_s2_f;
    t_side              n_s2_side;
    logic               w_h_rdy;

    assign w_s2_rdy     = !r_s2_v || w_h_rdy;
    assign w_ksum       = r_s1_p[31:0] + K_ROUND;
    assign w_k          = w_ksum[30:26];
    assign w_d          = {w_k, 26'd0} - r_s1_p[30:0];
    assign n_s2_f       = {w_d[26:0], 5'd0};
    assign n_s2_side.uf = r_s1_p > UNDERFLOW_LIM;
    assign n_s2_side.k  = w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_s2_rdy) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_rdy && r_s1_v) begin
            r_s2_f    <= n_s2_f;
            r_s2_side <= n_s2_side;
        end
    end

    // Stages 3 to 8: polynomial
    logic               w_h_v;
    logic signed [31:0] w_h_r;
    t_side              w_h_side;
    logic               w_s3_rdy;

    rctm_horner u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .o_ready (w_h_rdy),
        .i_f     (r_s2_f),
        .i_side  (r_s2_side),
        .o_valid (w_h_v),
        .i_ready (w_s3_rdy),
        .o_r     (w_h_r),
        .o_side  (w_h_side)
    );

    // Stage 9: round, shift by integer part, complement and drop 13 bits
    logic        r_s3_v;
    logic [13:0] r_s3_dh;
    logic [5:0]  w_shift;
    logic [31:0] w_half;
    logic [31:0] w_t;
    logic [31:0] w_e;
    logic [32:0] w_diff;
    logic [13:0] n_s3_dh;
    logic        w_s4_rdy;

    assign w_s3_rdy = !r_s3_v || w_s4_rdy;
    assign w_shift  = {1'b0, w_h_side.k} + 6'd5;
    assign w_half   = 32'd1 << (w_shift - 6'd1);
    assign w_t      = {w_h_r[30:0], 1'b0} + 32'h8000_0000 + w_half + 32'd1;
    assign w_e      = w_h_side.uf ? 32'd0 : (w_t >> w_shift);
    assign w_diff   = {6'd0, ONE_S26} - {1'b0, w_e};
    assign n_s3_dh  = w_diff[32] ? 14'd0 : w_diff[26:13];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_s3_rdy) begin
            r_s3_v <= w_h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_rdy && w_h_v) begin
            r_s3_dh <= n_s3_dh;
        end
    end

    // Stage 10: scale by full_scale into the output register
    logic        r_out_v;
    logic [15:0] r_mv;
    logic [29:0] w_scaled;

    assign w_s4_rdy = !r_out_v || i_out_ready;
    assign w_scaled = {16'd0, r_s3_dh} * {14'd0, r_full_scale};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_s4_rdy) begin
            r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s4_rdy && r_s3_v) begin
            r_mv <= w_scaled[28:13];
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_millivolts = r_mv;

    // Integer part stays within the polynomial's range unless the result saturates
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v && !r_s2_side.uf |-> r_s2_side.k <= 5'd26)
        else $error("exponent integer part out of range");

    // Complement never exceeds 1.0 after the 13-bit drop
    a_diff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v |-> r_s3_dh <= 14'd8192)
        else $error("exp2 complement out of range");

    // A held beat in stage 1 is neither lost nor altered
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !w_s2_rdy |=> r_s1_v && $stable(r_s1_p))
        else $error("stage 1 beat lost while stalled");

    // A held beat in stage 9 is neither lost nor altered
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v && !w_s4_rdy |=> r_s3_v && $stable(r_s3_dh))
        else $error("stage 9 beat lost while stalled");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the RC charge-time to millivolts converter.
module tb_top;
    import rctm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NUM_ROWS     = 25;
    localparam int          DRAIN_CYCLES = 14;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [63:0] SAT_LIMIT    = 64'h6a00_0000;

    // exp2 polynomial, highest order first (c6 in 2^-36 down to c1 in 2^-31)
    localparam longint POLY_COEF [6] = '{
        64'sd10535907, 64'sd46003595, 64'sd165241817,
        64'sd476772627, 64'sd1031764999, 64'sd1488522244
    };

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    // One directed step: a register write or a count beat with optional known result
    typedef struct packed {
        t_row_kind   kind;
        logic        cfg_idx;
        logic [15:0] cfg_data;
        logic [30:0] count;
        logic        has_mv;
        logic [15:0] mv;
    } t_stim_row;

    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        // reset settings: zero count, extremes, a single high bit, mid range
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'd0,          1'b1, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h7fff_ffff,  1'b1, 16'd6600},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'd1,          1'b0, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h4000_0000,  1'b1, 16'd6600},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h2000,       1'b0, 16'd0},
        // unit gain: product equals count, walk the underflow edge and half/one points
        '{ROW_CFG,  CFG_EXP_GAIN,   16'd1,     31'd0,          1'b0, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h6a00_0000,  1'b0, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h6a00_0001,  1'b1, 16'd6600},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h200_0000,   1'b0, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h1ff_ffff,   1'b0, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h400_0000,   1'b0, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h5555_5555,  1'b0, 16'd0},
        // full scale at max
        '{ROW_CFG,  CFG_FULL_SCALE, 16'hffff,  31'd0,          1'b0, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h7fff_ffff,  1'b1, 16'hffff},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h2aaa_aaaa,  1'b0, 16'd0},
        // gain at max, both sides of the underflow edge
        '{ROW_CFG,  CFG_EXP_GAIN,   16'hffff,  31'd0,          1'b0, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h7fff_ffff,  1'b1, 16'hffff},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'd27136,      1'b0, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'd27137,      1'b1, 16'hffff},
        // zero full scale
        '{ROW_CFG,  CFG_FULL_SCALE, 16'd0,     31'd0,          1'b0, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h1_2345,     1'b1, 16'd0},
        // zero gain: product is zero whatever the count
        '{ROW_CFG,  CFG_EXP_GAIN,   16'd0,     31'd0,          1'b0, 16'd0},
        '{ROW_CFG,  CFG_FULL_SCALE, 16'd6600,  31'd0,          1'b0, 16'd0},
        '{ROW_ITEM, CFG_EXP_GAIN,   16'd0,     31'h7fff_ffff,  1'b1, 16'd0},
        '{ROW_CFG,  CFG_EXP_GAIN,   16'd4034,  31'd0,          1'b0, 16'd0}
    };

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [30:0] i_charge_count = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [15:0] o_millivolts;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index    = CFG_EXP_GAIN;
    logic [15:0] i_cfg_data     = '0;

    // Known result that rides along with the beat on offer
    logic        known_flag = 1'b0;
    logic [15:0] known_mv   = '0;

    logic [15:0] gain_now = GAIN_RESET;
    logic [15:0] fs_now   = FULL_RESET;
    logic [15:0] pending_millivolts [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asked    = 0;
    int hold_given    = 0;
    int hold_left     = 0;

    int error_count  = 0;
    int beats_in     = 0;
    int beats_out    = 0;
    int cfg_writes   = 0;
    int sat_beats    = 0;
    int input_stalls = 0;

    rc_charge_time_to_millivolts_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_charge_count (i_charge_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_millivolts   (o_millivolts),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Exponent product of a count and a gain, at full width
    function automatic logic [63:0] exp_product(input logic [30:0] count,
                                                input logic [15:0] gain);
        return {33'd0, count} * {48'd0, gain};
    endfunction

    // Expected millivolts: full_scale * (1 - exp2(-count*gain / 2^26)) in fixed point
    function automatic logic [15:0] calc_millivolts(input logic [30:0] count,
                                                    input logic [15:0] gain,
                                                    input logic [15:0] fscale);
        logic [63:0] prod;
        longint      a;
        longint      k;
        longint      f;
        longint      r;
        longint      expo;
        longint      diff;
        longint      fs_l;
        longint      mv;
        logic [31:0] t;
        int          s;
        int          i;

        prod = exp_product(count, gain);
        if (prod > SAT_LIMIT) begin
            expo = 0;
        end else begin
            // split into integer part k and a fraction in [-0.5, 0.5), pre-scaled by 32
            a = -longint'(prod);
            k = -((a + 64'sh200_0000) >>> 26);
            f = (a + k * 64'sh400_0000) * 64'sd32;
            s = 5 + int'(k);
            // Horner, high half of each product with floor rounding
            r = POLY_COEF[0];
            for (i = 1; i < 6; i++) begin
                r = ((r * f) >>> 32) + POLY_COEF[i];
            end
            r = (r * f) >>> 32;
            // add one, round, and scale down by the integer part
            t = r[31:0];
            t = t << 1;
            t = t + 32'h8000_0000 + ((32'd1 << s) >> 1) + 32'd1;
            expo = longint'(t >> s);
        end
        diff = 64'sh400_0000 - expo;
        if (diff < 0) begin
            diff = 0;
        end
        fs_l = longint'({48'd0, fscale});
        mv = ((diff >>> 13) * fs_l) >>> 13;
        return mv[15:0];
    endfunction

    // Random count: mostly spread over the polynomial range of the current gain
    function automatic logic [30:0] pick_count(input logic [15:0] gain);
        logic [31:0] span;

        span = (gain == 16'd0) ? 32'h7fff_ffff : 32'h6a00_0000 / {16'd0, gain};
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                if (span > 32'h7fff_fffd) begin
                    span = 32'h7fff_fffd;
                end
                return 31'($urandom_range(span + 32'd2, 0));
            end
            6: begin
                return 31'($urandom);
            end
            7: begin
                return 31'($urandom_range(255));
            end
            8: begin
                if (gain == 16'd0 || span > 32'h7fff_fffd) begin
                    return 31'($urandom);
                end
                return 31'(span + $urandom_range(4) - 32'd2);
            end
            default: begin
                return 31'($urandom >> $urandom_range(31));
            end
        endcase
    endfunction

    // Scoreboard: results are checked before the beat of this edge is queued
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                beats_out++;
                if (pending_millivolts.size() == 0) begin
                    $error("millivolts: no beat expected, actual %0d", o_millivolts);
                    error_count++;
                end else if (o_millivolts !== pending_millivolts[0]) begin
                    $error("millivolts: expected %0d, actual %0d",
                           pending_millivolts[0], o_millivolts);
                    error_count++;
                    void'(pending_millivolts.pop_front());
                end else begin
                    void'(pending_millivolts.pop_front());
                end
            end
            if (i_in_valid && o_in_ready) begin
                beats_in++;
                if (exp_product(i_charge_count, gain_now) > SAT_LIMIT) begin
                    sat_beats++;
                end
                pending_millivolts.push_back(known_flag ? known_mv :
                    calc_millivolts(i_charge_count, gain_now, fs_now));
            end
            if (i_in_valid && !o_in_ready) begin
                input_stalls++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                case (i_cfg_index)
                    CFG_EXP_GAIN:   gain_now = i_cfg_data;
                    CFG_FULL_SCALE: fs_now   = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Output side: random stalls, plus a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_given != hold_asked) begin
            hold_given++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // Offer one count beat, after a random number of idle cycles
    task automatic send_count(input logic [30:0] count, input logic has_mv,
                              input logic [15:0] mv);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_charge_count <= count;
        known_flag     <= has_mv;
        known_mv       <= mv;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop offering and let the pipe empty out
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_millivolts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write, only with the pipe empty
    task automatic write_reg(input logic idx, input logic [15:0] data);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n, input int idle_pct, input int stall);
        int i;

        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (i = 0; i < n; i++) begin
            send_count(pick_count(gain_now), 1'b0, 16'd0);
        end
    endtask

    initial begin
        int row;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (row = 0; row < NUM_ROWS; row++) begin
            if (DIRECTED[row].kind == ROW_CFG) begin
                write_reg(DIRECTED[row].cfg_idx, DIRECTED[row].cfg_data);
            end else begin
                send_count(DIRECTED[row].count, DIRECTED[row].has_mv, DIRECTED[row].mv);
            end
        end

        // Random phases, settings changed between them with the pipe empty
        write_reg(CFG_FULL_SCALE, FULL_RESET);
        run_random(300, 0, 0);

        write_reg(CFG_EXP_GAIN, 16'hffff);
        write_reg(CFG_FULL_SCALE, 16'hffff);
        run_random(300, 57, 0);

        write_reg(CFG_EXP_GAIN, 16'd1);
        write_reg(CFG_FULL_SCALE, 16'($urandom));
        run_random(300, 0, 57);

        write_reg(CFG_EXP_GAIN, 16'($urandom));
        write_reg(CFG_FULL_SCALE, 16'($urandom));
        run_random(300, 9, 9);

        // Long output hold-off while the input keeps offering at full rate
        write_reg(CFG_EXP_GAIN, 16'($urandom_range(8000, 1)));
        write_reg(CFG_FULL_SCALE, FULL_RESET);
        hold_asked++;
        run_random(100, 0, 0);
        wait_drained();

        write_reg(CFG_EXP_GAIN, 16'($urandom));
        write_reg(CFG_FULL_SCALE, 16'($urandom));
        run_random(250, 30, 30);

        wait_drained();

        $display("Ran %0d count beats through %0d register writes, %0d of them saturated.",
                 beats_in, cfg_writes, sat_beats);
        $display("Input held off on %0d cycles; %0d results checked, %0d mismatches.",
                 input_stalls, beats_out, error_count);
        if (error_count == 0 && pending_millivolts.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
